[design/bmpd_pkg.sv]
package bmpd_pkg;

    localparam int DIM_W = 16;
    localparam int COL_W = DIM_W + 3;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int JOBQ_DEPTH     = 4;
    localparam int RESQ_DEPTH     = 2;

    localparam logic [1:0] K_INFO  = 2'd0;
    localparam logic [1:0] K_PAL   = 2'd1;
    localparam logic [1:0] K_PIXEL = 2'd2;
    localparam logic [1:0] K_ERROR = 2'd3;

    localparam logic [2:0] F_WIDTH  = 3'd0;
    localparam logic [2:0] F_HEIGHT = 3'd1;
    localparam logic [2:0] F_BPP    = 3'd2;
    localparam logic [2:0] F_RMASK  = 3'd3;
    localparam logic [2:0] F_GMASK  = 3'd4;
    localparam logic [2:0] F_BMASK  = 3'd5;
    localparam logic [2:0] F_PAD    = 3'd6;
    localparam logic [2:0] F_EXPAND = 3'd7;

    localparam logic [31:0] E_MAGIC    = 32'd0;
    localparam logic [31:0] E_COMPRESS = 32'd1;
    localparam logic [31:0] E_DEPTH    = 32'd2;
    localparam logic [31:0] E_SIZE     = 32'd3;
    localparam logic [31:0] E_OFFSET   = 32'd4;
    localparam logic [31:0] E_TRUNC    = 32'd5;

    localparam logic [31:0] M16_R = 32'h0000_7C00;
    localparam logic [31:0] M16_G = 32'h0000_03E0;
    localparam logic [31:0] M16_B = 32'h0000_001F;
    localparam logic [31:0] M24_R = 32'h00FF_0000;
    localparam logic [31:0] M24_G = 32'h0000_FF00;
    localparam logic [31:0] M24_B = 32'h0000_00FF;

    localparam logic [31:0] FILE_HDR_LEN = 32'd14;
    localparam logic [31:0] CORE_HDR_LEN = 32'd12;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       file_start;
        logic       file_end;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  info_field;
        logic [31:0] value;
        logic [11:0] row;
        logic [11:0] column;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        J_SINGLE = 2'd0,
        J_INFO   = 2'd1,
        J_EXPAND = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind        jk;
        t_out             res;
        logic [DIM_W-1:0] iw;
        logic [DIM_W-1:0] ih;
        logic [5:0]       bpp;
        logic [31:0]      m0;
        logic [31:0]      m1;
        logic [31:0]      m2;
        logic [1:0]       pad;
        logic [2:0]       expand;
        logic [7:0]       eb;
        logic [COL_W-1:0] ecol;
        logic             elast;
    } t_job;

endpackage

[design/bmpd_queue.sv]
module bmpd_queue import bmpd_pkg::*; #(
    parameter type T = logic,
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[design/bmpd_front.sv]
module bmpd_front import bmpd_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_job_valid,
    output t_job o_job
);

    localparam int RD_W = DIM_W + 2;
    localparam int RB_W = DIM_W + 3;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PALETTE = 5'b00100,
        PH_MASKS   = 5'b01000,
        PH_PIXELS  = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [31:0]       r_byte_count, n_byte_count;
    logic [31:0]       r_offset, n_offset;
    logic [31:0]       r_hsize, n_hsize;
    logic [31:0]       r_width, n_width;
    logic [31:0]       r_height, n_height;
    logic [15:0]       r_raw_bpp, n_raw_bpp;
    logic [31:0]       r_comp, n_comp;
    logic [31:0]       r_raw_clr, n_raw_clr;
    logic [5:0]        r_bpp, n_bpp;
    logic [2:0]        r_expand, n_expand;
    logic [8:0]        r_colors, n_colors;
    logic [31:0]       r_m0, n_m0;
    logic [31:0]       r_m1, n_m1;
    logic [31:0]       r_m2, n_m2;
    logic [1:0]        r_pad, n_pad;
    logic [RD_W-1:0]   r_row_data, n_row_data;
    logic [2:0]        r_px_bytes, n_px_bytes;
    logic [3:0]        r_fs, n_fs;
    logic [31:0]       r_acc, n_acc;
    logic [8:0]        r_pal_idx, n_pal_idx;
    logic [DIM_W-1:0]  r_row_cnt, n_row_cnt;
    logic [DIM_W-1:0]  r_col_cnt, n_col_cnt;
    logic [RB_W-1:0]   r_row_byte, n_row_byte;

    function automatic logic [31:0] put_le(input logic [31:0] dst, input logic [31:0] pos,
                                           input logic [31:0] start, input logic [2:0] len,
                                           input logic [7:0] b);
        logic [31:0] d;
        logic [31:0] off;
        d   = dst;
        off = pos - start;
        if (pos >= start && off < {29'd0, len}) begin
            d[8*off[1:0] +: 8] = b;
        end
        return d;
    endfunction

    function automatic t_job make_err(input logic [31:0] code);
        t_job j;
        j            = '0;
        j.jk         = J_SINGLE;
        j.res.kind   = K_ERROR;
        j.res.value  = code;
        j.res.last   = 1'b1;
        return j;
    endfunction

    function automatic logic n_phase_was_active(input logic start, input t_phase ph);
        return start || (ph != PH_IDLE);
    endfunction

    logic [7:0]        b;
    logic [31:0]       pos;
    logic [31:0]       tmp;
    logic [31:0]       hdr_end;
    logic              hd_bad_depth;
    logic [5:0]        hd_bpp;
    logic [2:0]        hd_exp;
    logic [8:0]        hd_colors;
    logic              hd_def;
    logic              hd_rm;
    logic [RD_W-1:0]   hd_rd;
    logic [11:0]       hd_pal_bytes;
    logic [31:0]       hd_need;
    logic [2:0]        esz;
    logic [31:0]       acc_new;
    logic [3:0]        fs_new;
    logic [8:0]        pal_new;
    logic [11:0]       px_row;
    logic              row_last;
    logic              fin;
    logic              stop;
    logic [RB_W-1:0]   rb_new;
    logic [DIM_W-1:0]  w16;

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_offset     = r_offset;
        n_hsize      = r_hsize;
        n_width      = r_width;
        n_height     = r_height;
        n_raw_bpp    = r_raw_bpp;
        n_comp       = r_comp;
        n_raw_clr    = r_raw_clr;
        n_bpp        = r_bpp;
        n_expand     = r_expand;
        n_colors     = r_colors;
        n_m0         = r_m0;
        n_m1         = r_m1;
        n_m2         = r_m2;
        n_pad        = r_pad;
        n_row_data   = r_row_data;
        n_px_bytes   = r_px_bytes;
        n_fs         = r_fs;
        n_acc        = r_acc;
        n_pal_idx    = r_pal_idx;
        n_row_cnt    = r_row_cnt;
        n_col_cnt    = r_col_cnt;
        n_row_byte   = r_row_byte;
        o_job_valid  = 1'b0;
        o_job        = '0;
        b            = i_item.byte_value;
        pos          = '0;
        tmp          = '0;
        hdr_end      = 32'd54;
        hd_bad_depth = 1'b0;
        hd_bpp       = '0;
        hd_exp       = '0;
        hd_colors    = '0;
        hd_def       = 1'b0;
        hd_rm        = 1'b0;
        hd_rd        = '0;
        hd_pal_bytes = '0;
        hd_need      = '0;
        esz          = (n_hsize == CORE_HDR_LEN) ? 3'd3 : 3'd4;
        acc_new      = '0;
        fs_new       = '0;
        pal_new      = '0;
        px_row       = '0;
        row_last     = 1'b0;
        fin          = 1'b0;
        stop         = 1'b0;
        rb_new       = '0;
        w16          = '0;
        if (i_valid) begin
            if (i_item.file_start) begin
                n_phase      = PH_HEADER;
                n_byte_count = '0;
                n_offset     = '0;
                n_hsize      = '0;
                n_width      = '0;
                n_height     = '0;
                n_raw_bpp    = '0;
                n_comp       = '0;
                n_raw_clr    = '0;
                n_bpp        = '0;
                n_expand     = '0;
                n_colors     = '0;
                n_m0         = '0;
                n_m1         = '0;
                n_m2         = '0;
                n_pad        = '0;
                n_row_data   = '0;
                n_px_bytes   = '0;
                n_fs         = '0;
                n_acc        = '0;
                n_pal_idx    = '0;
                n_row_cnt    = '0;
                n_col_cnt    = '0;
                n_row_byte   = '0;
            end
            pos = n_byte_count;
            case (n_phase)
                PH_IDLE: begin
                end
                PH_HEADER: begin
                    if ((pos == 32'd0 && b != 8'h42) || (pos == 32'd1 && b != 8'h4D)) begin
                        o_job_valid = 1'b1;
                        o_job       = make_err(E_MAGIC);
                        n_phase     = PH_IDLE;
                    end else begin
                        n_offset = put_le(n_offset, pos, 32'd10, 3'd4, b);
                        n_hsize  = put_le(n_hsize, pos, 32'd14, 3'd4, b);
                        if (pos >= 32'd18) begin
                            if (n_hsize == CORE_HDR_LEN) begin
                                n_width   = put_le(n_width, pos, 32'd18, 3'd2, b);
                                n_height  = put_le(n_height, pos, 32'd20, 3'd2, b);
                                tmp       = put_le({16'd0, n_raw_bpp}, pos, 32'd24, 3'd2, b);
                                n_raw_bpp = tmp[15:0];
                                hdr_end   = 32'd26;
                            end else begin
                                n_width   = put_le(n_width, pos, 32'd18, 3'd4, b);
                                n_height  = put_le(n_height, pos, 32'd22, 3'd4, b);
                                tmp       = put_le({16'd0, n_raw_bpp}, pos, 32'd28, 3'd2, b);
                                n_raw_bpp = tmp[15:0];
                                n_comp    = put_le(n_comp, pos, 32'd30, 3'd4, b);
                                n_raw_clr = put_le(n_raw_clr, pos, 32'd46, 3'd4, b);
                                hdr_end   = 32'd54;
                            end
                            if (pos == hdr_end - 32'd1) begin
                                case (n_raw_bpp)
                                    16'd1: begin
                                        hd_exp = 3'd1;
                                        hd_bpp = 6'd8;
                                    end
                                    16'd4: begin
                                        hd_exp = 3'd4;
                                        hd_bpp = 6'd8;
                                    end
                                    16'd8: hd_bpp = 6'd8;
                                    16'd15, 16'd16: hd_bpp = 6'd16;
                                    16'd24: hd_bpp = 6'd24;
                                    16'd32: hd_bpp = 6'd32;
                                    default: hd_bad_depth = 1'b1;
                                endcase
                                w16 = n_width[DIM_W-1:0];
                                if (n_raw_bpp <= 16'd8) begin
                                    if (n_raw_clr == 32'd0) begin
                                        hd_colors = 9'd1 << n_raw_bpp[3:0];
                                    end else if (n_raw_clr > 32'd256) begin
                                        hd_colors = 9'd256;
                                    end else begin
                                        hd_colors = n_raw_clr[8:0];
                                    end
                                end
                                hd_def = (n_comp == 32'd0) &&
                                         ({1'b0, n_offset} == {1'b0, n_hsize} + 33'd14);
                                hd_rm  = !hd_def && (hd_bpp == 6'd16 || hd_bpp == 6'd32);
                                if (hd_exp == 3'd1) begin
                                    hd_rd = RD_W'(({2'b0, w16} + 18'd7) >> 3);
                                end else if (hd_exp == 3'd4) begin
                                    hd_rd = RD_W'(({2'b0, w16} + 18'd1) >> 1);
                                end else begin
                                    case (hd_bpp)
                                        6'd8:  hd_rd = {2'b0, w16};
                                        6'd16: hd_rd = {1'b0, w16, 1'b0};
                                        6'd24: hd_rd = {1'b0, w16, 1'b0} + {2'b0, w16};
                                        default: hd_rd = {w16, 2'b0};
                                    endcase
                                end
                                if (esz == 3'd3) begin
                                    hd_pal_bytes = {3'd0, hd_colors} + {2'd0, hd_colors, 1'b0};
                                end else begin
                                    hd_pal_bytes = {1'b0, hd_colors, 2'b0};
                                end
                                hd_need = hdr_end + {20'd0, hd_pal_bytes} +
                                          (hd_rm ? 32'd12 : 32'd0);
                                if (n_comp != 32'd0 && n_comp != 32'd3) begin
                                    o_job_valid = 1'b1;
                                    o_job       = make_err(E_COMPRESS);
                                    n_phase     = PH_IDLE;
                                end else if (hd_bad_depth) begin
                                    o_job_valid = 1'b1;
                                    o_job       = make_err(E_DEPTH);
                                    n_phase     = PH_IDLE;
                                end else if (n_width == 32'd0 || n_height == 32'd0 ||
                                             n_width > 32'(MAX_WIDTH) ||
                                             n_height > 32'(MAX_HEIGHT)) begin
                                    o_job_valid = 1'b1;
                                    o_job       = make_err(E_SIZE);
                                    n_phase     = PH_IDLE;
                                end else if (n_offset < hd_need) begin
                                    o_job_valid = 1'b1;
                                    o_job       = make_err(E_OFFSET);
                                    n_phase     = PH_IDLE;
                                end else begin
                                    n_bpp      = hd_bpp;
                                    n_expand   = hd_exp;
                                    n_colors   = hd_colors;
                                    n_m0       = '0;
                                    n_m1       = '0;
                                    n_m2       = '0;
                                    if (hd_def && hd_bpp == 6'd16) begin
                                        n_m0 = M16_R;
                                        n_m1 = M16_G;
                                        n_m2 = M16_B;
                                    end else if (hd_def && (hd_bpp == 6'd24 ||
                                                            hd_bpp == 6'd32)) begin
                                        n_m0 = M24_R;
                                        n_m1 = M24_G;
                                        n_m2 = M24_B;
                                    end
                                    n_row_data = hd_rd;
                                    n_pad      = 2'd0 - hd_rd[1:0];
                                    n_px_bytes = hd_bpp[5:3];
                                    n_fs       = '0;
                                    n_acc      = '0;
                                    n_pal_idx  = '0;
                                    if (hd_rm) begin
                                        n_phase = PH_MASKS;
                                    end else begin
                                        o_job_valid = 1'b1;
                                        n_phase = (hd_colors != 9'd0) ? PH_PALETTE : PH_PIXELS;
                                    end
                                end
                            end
                        end
                    end
                end
                PH_PALETTE: begin
                    acc_new = n_acc | ({24'd0, b} << (8 * n_fs[1:0]));
                    fs_new  = n_fs + 4'd1;
                    if (fs_new >= {1'b0, esz}) begin
                        o_job_valid      = 1'b1;
                        o_job.jk         = J_SINGLE;
                        o_job.res.kind   = K_PAL;
                        o_job.res.value  = {(esz == 3'd4) ? acc_new[31:24] : 8'hFF,
                                            acc_new[23:0]};
                        o_job.res.column = {3'd0, n_pal_idx};
                        pal_new          = n_pal_idx + 9'd1;
                        o_job.res.last   = (pal_new >= n_colors);
                        n_pal_idx        = pal_new;
                        n_fs             = '0;
                        n_acc            = '0;
                        if (pal_new >= n_colors) begin
                            n_phase = PH_PIXELS;
                        end
                    end else begin
                        n_fs  = fs_new;
                        n_acc = acc_new;
                    end
                end
                PH_MASKS: begin
                    case (n_fs[3:2])
                        2'd0: n_m0[8*n_fs[1:0] +: 8] = b;
                        2'd1: n_m1[8*n_fs[1:0] +: 8] = b;
                        2'd2: n_m2[8*n_fs[1:0] +: 8] = b;
                        default: begin
                        end
                    endcase
                    fs_new = n_fs + 4'd1;
                    n_fs   = fs_new;
                    if (fs_new >= 4'd12) begin
                        n_fs        = '0;
                        o_job_valid = 1'b1;
                        n_phase     = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    px_row   = n_height[11:0] - 12'd1 - n_row_cnt[11:0];
                    row_last = ({1'b0, n_row_cnt} + 17'd1) >= n_height[DIM_W:0];
                    if (pos >= n_offset) begin
                        if (n_row_byte < {1'b0, n_row_data}) begin
                            fin = row_last &&
                                  (n_row_byte == {1'b0, n_row_data} - RB_W'(1));
                            if (n_expand != 3'd0) begin
                                o_job_valid     = 1'b1;
                                o_job.jk        = J_EXPAND;
                                o_job.res.kind  = K_PIXEL;
                                o_job.res.row   = px_row;
                                o_job.iw        = n_width[DIM_W-1:0];
                                o_job.expand    = n_expand;
                                o_job.eb        = b;
                                o_job.elast     = row_last;
                                o_job.ecol      = (n_expand == 3'd1) ?
                                                  COL_W'(n_row_byte << 3) :
                                                  COL_W'(n_row_byte << 1);
                                if (fin) begin
                                    n_phase = PH_IDLE;
                                    stop    = 1'b1;
                                end
                            end else begin
                                acc_new = n_acc | ({24'd0, b} << (8 * n_fs[1:0]));
                                fs_new  = n_fs + 4'd1;
                                n_fs    = fs_new;
                                n_acc   = acc_new;
                                if (fs_new >= {1'b0, n_px_bytes}) begin
                                    o_job_valid      = 1'b1;
                                    o_job.jk         = J_SINGLE;
                                    o_job.res.kind   = K_PIXEL;
                                    o_job.res.value  = acc_new;
                                    o_job.res.row    = px_row;
                                    o_job.res.column = n_col_cnt[11:0];
                                    fin = row_last && ({1'b0, n_col_cnt} + 17'd1 ==
                                                       {1'b0, n_width[DIM_W-1:0]});
                                    o_job.res.last   = fin;
                                    n_col_cnt        = n_col_cnt + DIM_W'(1);
                                    n_fs             = '0;
                                    n_acc            = '0;
                                    if (fin) begin
                                        n_phase = PH_IDLE;
                                        stop    = 1'b1;
                                    end
                                end
                            end
                        end
                        if (!stop) begin
                            rb_new = n_row_byte + RB_W'(1);
                            if (rb_new >= {1'b0, n_row_data} + RB_W'(n_pad)) begin
                                n_row_byte = '0;
                                n_col_cnt  = '0;
                                n_fs       = '0;
                                n_acc      = '0;
                                n_row_cnt  = n_row_cnt + DIM_W'(1);
                            end else begin
                                n_row_byte = rb_new;
                            end
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
            if (o_job_valid && o_job.jk == J_SINGLE && o_job.res.kind == K_ERROR) begin
                o_job.jk = J_SINGLE;
            end else if (o_job_valid && o_job.jk == J_SINGLE && o_job.res.kind == K_INFO) begin
                o_job.jk     = J_INFO;
                o_job.iw     = n_width[DIM_W-1:0];
                o_job.ih     = n_height[DIM_W-1:0];
                o_job.bpp    = n_bpp;
                o_job.m0     = n_m0;
                o_job.m1     = n_m1;
                o_job.m2     = n_m2;
                o_job.pad    = n_pad;
                o_job.expand = n_expand;
            end
            if (n_phase_was_active(i_item.file_start, r_phase)) begin
                if (n_byte_count != 32'hFFFF_FFFF) begin
                    n_byte_count = n_byte_count + 32'd1;
                end
            end
            if (i_item.file_end && n_phase != PH_IDLE) begin
                o_job_valid = 1'b1;
                o_job       = make_err(E_TRUNC);
                n_phase     = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= '0;
            r_fs         <= '0;
            r_acc        <= '0;
            r_pal_idx    <= '0;
            r_row_cnt    <= '0;
            r_col_cnt    <= '0;
            r_row_byte   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_fs         <= n_fs;
            r_acc        <= n_acc;
            r_pal_idx    <= n_pal_idx;
            r_row_cnt    <= n_row_cnt;
            r_col_cnt    <= n_col_cnt;
            r_row_byte   <= n_row_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset   <= n_offset;
        r_hsize    <= n_hsize;
        r_width    <= n_width;
        r_height   <= n_height;
        r_raw_bpp  <= n_raw_bpp;
        r_comp     <= n_comp;
        r_raw_clr  <= n_raw_clr;
        r_bpp      <= n_bpp;
        r_expand   <= n_expand;
        r_colors   <= n_colors;
        r_m0       <= n_m0;
        r_m1       <= n_m1;
        r_m2       <= n_m2;
        r_pad      <= n_pad;
        r_row_data <= n_row_data;
        r_px_bytes <= n_px_bytes;
    end

endmodule

[design/bmpd_back.sv]
module bmpd_back import bmpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    input  logic i_res_ready,
    output logic o_res_valid,
    output t_out o_res
);

    logic [2:0]       r_step, n_step;
    logic             fire;
    logic             done;
    logic             res_v;
    logic [COL_W-1:0] col;
    logic             in_row;
    logic             lst;

    always_comb begin
        o_res  = '0;
        res_v  = 1'b0;
        done   = 1'b1;
        col    = '0;
        in_row = 1'b0;
        lst    = 1'b0;
        case (i_job.jk)
            J_SINGLE: begin
                o_res = i_job.res;
                res_v = 1'b1;
            end
            J_INFO: begin
                res_v            = 1'b1;
                o_res.kind       = K_INFO;
                o_res.info_field = r_step;
                o_res.last       = (r_step == F_EXPAND);
                done             = (r_step == F_EXPAND);
                case (r_step)
                    F_WIDTH:  o_res.value = 32'(i_job.iw);
                    F_HEIGHT: o_res.value = 32'(i_job.ih);
                    F_BPP:    o_res.value = 32'(i_job.bpp);
                    F_RMASK:  o_res.value = i_job.m0;
                    F_GMASK:  o_res.value = i_job.m1;
                    F_BMASK:  o_res.value = i_job.m2;
                    F_PAD:    o_res.value = 32'(i_job.pad);
                    default:  o_res.value = 32'(i_job.expand);
                endcase
            end
            J_EXPAND: begin
                col          = i_job.ecol + COL_W'(r_step);
                in_row       = col < COL_W'(i_job.iw);
                lst          = i_job.elast && (col + COL_W'(1) == COL_W'(i_job.iw));
                res_v        = in_row;
                o_res.kind   = K_PIXEL;
                o_res.row    = i_job.res.row;
                o_res.column = col[11:0];
                o_res.last   = lst;
                if (i_job.expand == 3'd1) begin
                    o_res.value = {31'd0, i_job.eb[3'd7 - r_step]};
                end else begin
                    o_res.value = {28'd0, (r_step == 3'd0) ? i_job.eb[7:4] : i_job.eb[3:0]};
                end
                done = (in_row && lst) ||
                       (r_step == ((i_job.expand == 3'd1) ? 3'd7 : 3'd1));
            end
            default: begin
            end
        endcase
    end

    assign fire        = i_job_valid && i_res_ready;
    assign o_res_valid = fire && res_v;
    assign o_job_pop   = fire && done;
    assign n_step      = fire ? (done ? 3'd0 : r_step + 3'd1) : r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[design/bmp_stream_decoder_unit.sv]
// Streaming BMP decoder: one file byte is taken per cycle whenever full is low, and each byte
// is parsed at once into at most one job for a four-entry job queue; the back end turns a job
// into results at one per cycle into a two-entry result queue whenever that queue is not full.
// Palette entries, byte-sized pixels and errors give one result each, the info run gives eight
// results, and a 1 bpp or 4 bpp data byte gives at most eight or two, so the byte rate drops
// only while the job queue is full, as when sub-byte pixels expand or results are not popped.
module bmp_stream_decoder_unit import bmpd_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_in  i_item,
    output logic full,
    input  logic pop,
    output logic empty,
    output t_out o_result
);

    logic front_valid;
    logic job_valid;
    t_job front_job;
    t_job head_job;
    logic job_empty;
    logic job_pop;
    logic res_full;
    logic res_valid;
    t_out res;

    assign front_valid = push && !full;

    bmpd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (front_valid),
        .i_item     (i_item),
        .o_job_valid(job_valid),
        .o_job      (front_job)
    );

    bmpd_queue #(
        .T    (t_job),
        .DEPTH(JOBQ_DEPTH)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_valid),
        .i_data (front_job),
        .o_full (full),
        .i_pop  (job_pop),
        .o_data (head_job),
        .o_empty(job_empty)
    );

    bmpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!job_empty),
        .i_job      (head_job),
        .o_job_pop  (job_pop),
        .i_res_ready(!res_full),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    bmpd_queue #(
        .T    (t_out),
        .DEPTH(RESQ_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_data (res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );

endmodule
